/* rtl/core/ddsv_pkg.sv */
`timescale 1ns / 1ps

package ddsv_pkg;

    // character codes
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] DIGIT_LO   = 8'h30;
    localparam logic [7:0] DIGIT_HI   = 8'h39;

    // counter limits
    localparam logic [3:0] COUNT_SAT  = 4'd11;
    localparam logic [1:0] DOT_SAT    = 2'd3;
    localparam logic [2:0] YEAR_DIGS  = 3'd4;
    localparam logic [3:0] MIN_LEN    = 4'd8;
    localparam logic [3:0] MAX_LEN    = 4'd10;

    // month codes and lengths
    localparam logic [6:0] MONTH_FEB  = 7'd2;
    localparam logic [6:0] MONTH_APR  = 7'd4;
    localparam logic [6:0] MONTH_JUN  = 7'd6;
    localparam logic [6:0] MONTH_SEP  = 7'd9;
    localparam logic [6:0] MONTH_NOV  = 7'd11;
    localparam logic [6:0] MONTH_MAX  = 7'd12;
    localparam logic [6:0] DAYS_29    = 7'd29;
    localparam logic [6:0] DAYS_28    = 7'd28;
    localparam logic [6:0] DAYS_30    = 7'd30;
    localparam logic [6:0] DAYS_31    = 7'd31;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in_word;

    typedef struct packed {
        logic        date_ok;
        logic [6:0]  day_value;
        logic [6:0]  month_value;
        logic [13:0] year_value;
    } t_out_word;

    // everything the back end needs to judge one finished text
    typedef struct packed {
        logic [3:0]  char_count;
        logic [1:0]  dot_count;
        logic [3:0]  first_dot_pos;
        logic [3:0]  second_dot_pos;
        logic        bad_char;
        logic [6:0]  day_acc;
        logic [6:0]  month_acc;
        logic [13:0] year_acc;
        logic        cent_zero;   // last two year digits are both zero
        logic [1:0]  hi_mod4;     // (year / 100) mod 4
    } t_summary;

endpackage

/* rtl/core/ddsv_front.sv */
`timescale 1ns / 1ps

module ddsv_front
    import ddsv_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_word i_word,
    output logic     o_push,
    output t_summary o_summary
);

    logic [3:0]  r_char_count, n_char_count;
    logic [1:0]  r_dot_count, n_dot_count;
    logic [3:0]  r_first_pos, n_first_pos;
    logic [3:0]  r_second_pos, n_second_pos;
    logic        r_bad, n_bad;
    logic [6:0]  r_day, n_day;
    logic [6:0]  r_month, n_month;
    logic [13:0] r_year, n_year;
    logic [2:0]  r_ydigs, n_ydigs;
    logic [3:0]  r_tens, n_tens;
    logic [3:0]  r_units, n_units;
    logic [1:0]  r_hi, n_hi;

    logic        is_dot;
    logic        is_digit;
    logic [3:0]  digit;
    logic [3:0]  hi_sum;

    assign is_dot   = (i_word.ch == DOT_CHAR);
    assign is_digit = (i_word.ch >= DIGIT_LO) && (i_word.ch <= DIGIT_HI);
    assign digit    = i_word.ch[3:0];
    // hi*10 + tens, mod 4
    assign hi_sum   = {1'b0, r_hi, 1'b0} + r_tens;

    always_comb begin
        n_char_count = r_char_count;
        n_dot_count  = r_dot_count;
        n_first_pos  = r_first_pos;
        n_second_pos = r_second_pos;
        n_bad        = r_bad;
        n_day        = r_day;
        n_month      = r_month;
        n_year       = r_year;
        n_ydigs      = r_ydigs;
        n_tens       = r_tens;
        n_units      = r_units;
        n_hi         = r_hi;
        if (is_dot) begin
            if (r_dot_count == 2'd0) begin
                n_first_pos = r_char_count;
            end else if (r_dot_count == 2'd1) begin
                n_second_pos = r_char_count;
            end
            if (r_dot_count < DOT_SAT) begin
                n_dot_count = r_dot_count + 2'd1;
            end
        end else if (is_digit) begin
            if (r_dot_count == 2'd0) begin
                n_day = 7'({r_day, 3'b000} + {r_day, 1'b0} + {3'b000, digit});
            end else if (r_dot_count == 2'd1) begin
                n_month = 7'({r_month, 3'b000} + {r_month, 1'b0} + {3'b000, digit});
            end else if (r_dot_count == 2'd2 && r_ydigs < YEAR_DIGS) begin
                n_year  = 14'({r_year, 3'b000} + {r_year, 1'b0} + {10'd0, digit});
                n_ydigs = r_ydigs + 3'd1;
                n_hi    = hi_sum[1:0];
                n_tens  = r_units;
                n_units = digit;
            end
        end else begin
            n_bad = 1'b1;
        end
        if (r_char_count < COUNT_SAT) begin
            n_char_count = r_char_count + 4'd1;
        end
    end

    always_comb begin
        o_push                   = i_accept && i_word.last;
        o_summary.char_count     = n_char_count;
        o_summary.dot_count      = n_dot_count;
        o_summary.first_dot_pos  = n_first_pos;
        o_summary.second_dot_pos = n_second_pos;
        o_summary.bad_char       = n_bad;
        o_summary.day_acc        = n_day;
        o_summary.month_acc      = n_month;
        o_summary.year_acc       = n_year;
        o_summary.cent_zero      = (n_tens == 4'd0) && (n_units == 4'd0);
        o_summary.hi_mod4        = n_hi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_word.last)) begin
            r_char_count <= '0;
            r_dot_count  <= '0;
            r_first_pos  <= '0;
            r_second_pos <= '0;
            r_bad        <= 1'b0;
            r_day        <= '0;
            r_month      <= '0;
            r_year       <= '0;
            r_ydigs      <= '0;
            r_tens       <= '0;
            r_units      <= '0;
            r_hi         <= '0;
        end else if (i_accept) begin
            r_char_count <= n_char_count;
            r_dot_count  <= n_dot_count;
            r_first_pos  <= n_first_pos;
            r_second_pos <= n_second_pos;
            r_bad        <= n_bad;
            r_day        <= n_day;
            r_month      <= n_month;
            r_year       <= n_year;
            r_ydigs      <= n_ydigs;
            r_tens       <= n_tens;
            r_units      <= n_units;
            r_hi         <= n_hi;
        end
    end

endmodule

/* rtl/core/ddsv_queue.sv */
`timescale 1ns / 1ps

module ddsv_queue
    import ddsv_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_summary i_data,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_summary o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_summary      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("queue count did not grow on push");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == FULL_CNT) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers out of step with count");

endmodule

/* rtl/core/ddsv_back.sv */
`timescale 1ns / 1ps

module ddsv_back
    import ddsv_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_summary  i_summary,
    output logic      o_take,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_word o_data
);

    logic      r_valid;
    t_out_word r_data;
    t_out_word n_data;
    logic      ok;
    logic      leap;
    logic [6:0] mlen;
    logic [3:0] gap;

    always_comb begin
        leap = (i_summary.year_acc != '0) && (i_summary.year_acc[1:0] == 2'b00) &&
               (!i_summary.cent_zero || (i_summary.hi_mod4 == 2'b00));
        unique case (i_summary.month_acc) inside
            MONTH_FEB: mlen = leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: mlen = DAYS_30;
            default: mlen = DAYS_31;
        endcase
        gap = i_summary.second_dot_pos - i_summary.first_dot_pos;
        ok  = (i_summary.char_count >= MIN_LEN) && (i_summary.char_count <= MAX_LEN) &&
              !i_summary.bad_char && (i_summary.dot_count == 2'd2) &&
              (i_summary.first_dot_pos >= 4'd1) && (i_summary.first_dot_pos <= 4'd2) &&
              (i_summary.second_dot_pos >= 4'd3) && (i_summary.second_dot_pos <= 4'd5) &&
              (gap >= 4'd2) && (gap <= 4'd3) &&
              (i_summary.month_acc >= 7'd1) && (i_summary.month_acc <= MONTH_MAX) &&
              (i_summary.day_acc >= 7'd1) && (i_summary.day_acc <= mlen);
        n_data.date_ok     = ok;
        n_data.day_value   = ok ? i_summary.day_acc   : '0;
        n_data.month_value = ok ? i_summary.month_acc : '0;
        n_data.year_value  = ok ? i_summary.year_acc  : '0;
    end

    // output register refills in the same cycle it is popped, if the queue holds a summary
    assign o_take  = i_valid && (!r_valid || i_pop);
    assign o_empty = !r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_data.date_ok) |->
        (r_data.day_value == '0 && r_data.month_value == '0 && r_data.year_value == '0))
        else $error("rejected date carries nonzero fields");

    a_ok_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_data.date_ok) |->
        (r_data.month_value >= 7'd1 && r_data.month_value <= MONTH_MAX &&
         r_data.day_value >= 7'd1 && r_data.day_value <= DAYS_31))
        else $error("accepted date out of range");

    a_take_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |=> r_valid)
        else $error("output register not filled after take");

endmodule

/* rtl/core/dotted_date_string_validator.sv */
`timescale 1ns / 1ps

// channel   direction  handshake                 word
// -------   ---------  ------------------------  --------------------------------
// input     in         i_push / o_full           i_data  : ch[7:0], last
// result    out        o_empty / i_pop           o_data  : date_ok, day, month, year
//
// One character is taken per cycle while o_full is low, so texts of any length stream back to back.
// A verdict passes from the summary queue into the output register and shows on
// o_data when the output word is free; otherwise it waits in the queue.
// The front tracks counters and digit fields; a small summary queue parts it
// from the back, which judges the date into a one-word output register.
// o_full is high while the summary queue holds QDEPTH texts, which happens only
// when the output word has been left unpopped.
// i_rst_n is synchronous, active low, and clears all counters and the queue.
module dotted_date_string_validator
    import ddsv_pkg::*;
#(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    output logic      o_full,
    input  t_in_word  i_data,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_word o_data
);

    logic     accept;
    logic     sum_push;
    t_summary sum_in;
    logic     q_valid;
    t_summary q_data;
    logic     q_take;

    // a word is taken whenever the summary queue has room
    assign accept = i_push && !o_full;

    ddsv_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_word    (i_data),
        .o_push    (sum_push),
        .o_summary (sum_in)
    );

    // finished-text summaries wait here for the verdict stage
    ddsv_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (sum_push),
        .i_data  (sum_in),
        .o_full  (o_full),
        .i_pop   (q_take),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    // verdict logic and the result register
    ddsv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_summary (q_data),
        .o_take    (q_take),
        .i_pop     (i_pop),
        .o_empty   (o_empty),
        .o_data    (o_data)
    );

endmodule

/* tb/sv/dotted_date_string_validator_test.sv */
`timescale 1ns / 1ps

module dotted_date_string_validator_test;
    import ddsv_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 6;
    localparam int CHARS_PER_PHASE = 500;
    localparam int HOLD_CYCLES   = 80;
    localparam int PRESSURE_TEXTS = 40;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 200000;

    // Shadow of the front end: counters and digit fields of the text in
    // flight, plus the queue of verdicts still owed by the block.
    class date_scoreboard;
        logic [3:0]  n_chars;
        logic [1:0]  n_dots;
        logic [3:0]  dot1_pos;
        logic [3:0]  dot2_pos;
        logic        bad_seen;
        logic [6:0]  day_digits;
        logic [6:0]  month_digits;
        logic [13:0] year_digits;
        logic [2:0]  year_len;
        t_out_word   expected_dates[$];
        int          mismatches;

        function new();
            clear_text();
            mismatches = 0;
        endfunction

        function void clear_text();
            n_chars      = '0;
            n_dots       = '0;
            dot1_pos     = '0;
            dot2_pos     = '0;
            bad_seen     = 1'b0;
            day_digits   = '0;
            month_digits = '0;
            year_digits  = '0;
            year_len     = '0;
        endfunction

        function logic [6:0] month_days(logic [6:0] month, logic [13:0] year);
            bit leap;
            leap = (year > 0) && (year % 4 == 0) && ((year % 400 == 0) || (year % 100 != 0));
            if (month == MONTH_FEB)
                return leap ? DAYS_29 : DAYS_28;
            if (month == MONTH_APR || month == MONTH_JUN || month == MONTH_SEP ||
                month == MONTH_NOV)
                return DAYS_30;
            return DAYS_31;
        endfunction

        function bit date_valid();
            logic [3:0] gap;
            if (n_chars < MIN_LEN || n_chars > MAX_LEN) return 1'b0;
            if (bad_seen || n_dots != 2'd2) return 1'b0;
            if (dot1_pos < 4'd1 || dot1_pos > 4'd2) return 1'b0;
            if (dot2_pos < 4'd3 || dot2_pos > 4'd5) return 1'b0;
            if (dot2_pos < dot1_pos) return 1'b0;
            gap = dot2_pos - dot1_pos;
            if (gap < 4'd2 || gap > 4'd3) return 1'b0;
            if (month_digits < 7'd1 || month_digits > MONTH_MAX) return 1'b0;
            if (day_digits < 7'd1 || day_digits > month_days(month_digits, year_digits))
                return 1'b0;
            return 1'b1;
        endfunction

        // one accepted input word
        function void note_word(t_in_word w);
            logic [3:0] pos;
            int         digit;
            t_out_word  res;
            bit         ok;
            pos = n_chars;
            if (w.ch == DOT_CHAR) begin
                if (n_dots == 2'd0) dot1_pos = pos;
                else if (n_dots == 2'd1) dot2_pos = pos;
                if (n_dots < DOT_SAT) n_dots = n_dots + 2'd1;
            end else if (w.ch >= DIGIT_LO && w.ch <= DIGIT_HI) begin
                digit = int'(w.ch - DIGIT_LO);
                if (n_dots == 2'd0) begin
                    day_digits = 7'(int'(day_digits) * 10 + digit);
                end else if (n_dots == 2'd1) begin
                    month_digits = 7'(int'(month_digits) * 10 + digit);
                end else if (n_dots == 2'd2 && year_len < YEAR_DIGS) begin
                    year_digits = 14'(int'(year_digits) * 10 + digit);
                    year_len = year_len + 3'd1;
                end
            end else begin
                bad_seen = 1'b1;
            end
            if (n_chars < COUNT_SAT) n_chars = n_chars + 4'd1;

            if (w.last) begin
                ok = date_valid();
                res.date_ok     = ok;
                res.day_value   = ok ? day_digits : '0;
                res.month_value = ok ? month_digits : '0;
                res.year_value  = ok ? year_digits : '0;
                expected_dates = {expected_dates, res};
                clear_text();
            end
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
            mismatches++;
        endtask

        task check_date(t_out_word got);
            t_out_word want;
            if (expected_dates.size() == 0) begin
                report_mismatch("unexpected word", int'(got), 0);
                return;
            end
            want = expected_dates.pop_front();
            if (got.date_ok !== want.date_ok)
                report_mismatch("date_ok", int'(got.date_ok), int'(want.date_ok));
            if (got.day_value !== want.day_value)
                report_mismatch("day_value", int'(got.day_value), int'(want.day_value));
            if (got.month_value !== want.month_value)
                report_mismatch("month_value", int'(got.month_value),
                                int'(want.month_value));
            if (got.year_value !== want.year_value)
                report_mismatch("year_value", int'(got.year_value), int'(want.year_value));
        endtask

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      i_push;
    logic      o_full;
    t_in_word  i_data;
    logic      o_empty;
    logic      i_pop;
    t_out_word o_data;

    date_scoreboard sb;

    // idle percentages per phase, set by the main sequence
    int send_idle_pct;
    int pop_stall_pct;

    // long receiver hold-off: main bumps the token, the receiver counts
    int hold_token;
    int hold_seen;
    int hold_left;

    int sent_chars;
    int cycle_count;

    // years that exercise the leap rule, year zero and the top of range
    int leap_years[8] = '{0, 1900, 2000, 2024, 2100, 2400, 1996, 9999};

    dotted_date_string_validator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (i_data),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_data)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watchdog: a hang or a lost verdict ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: check the word taken at this edge, then pick pop for the next.
    // Values read here are the pre-edge ones, since all drivers use NBAs.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty)
                sb.check_date(o_data);
            if (hold_token != hold_seen) begin
                hold_seen <= hold_token;
                hold_left <= HOLD_CYCLES;
                i_pop     <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_pop     <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(0, 99) >= pop_stall_pct);
            end
        end
    end

    // Offer one word, with random idle cycles first; returns after the edge
    // that accepts it. push stays high so back-to-back words stream.
    task send_word(input t_in_word w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data <= w;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sb.note_word(w);
        sent_chars++;
    endtask

    task send_text(input byte unsigned txt[$]);
        t_in_word w;
        for (int i = 0; i < txt.size(); i++) begin
            w.ch   = txt[i];
            w.last = (i == txt.size() - 1);
            send_word(w);
        end
    endtask

    task send_string(input string s);
        byte unsigned txt[$];
        for (int i = 0; i < s.len(); i++) txt = {txt, s[i]};
        send_text(txt);
    endtask

    // decimal digits of value, zero-padded to width (widened if needed)
    function automatic void append_digits(ref byte unsigned txt[$], input int value,
                                          input int width);
        int n;
        int t;
        int p;
        n = 1;
        t = value;
        while (t >= 10) begin
            t = t / 10;
            n++;
        end
        if (width < n) width = n;
        for (int i = width - 1; i >= 0; i--) begin
            p = 1;
            repeat (i) p = p * 10;
            txt = {txt, 8'(8'h30 + (value / p) % 10)};
        end
    endfunction

    function automatic byte unsigned noise_char();
        case ($urandom_range(0, 3)) inside
            0: return DOT_CHAR;
            1, 2: return 8'(8'h30 + $urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed d.m.yyyy texts with random fields; some corrupted,
    // some pure noise of random length.
    task send_random_text();
        byte unsigned txt[$];
        int kind;
        int day;
        int month;
        int year;
        int yw;
        int at;
        kind  = $urandom_range(0, 99);
        day   = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        month = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        year  = ($urandom_range(0, 2) == 0) ? leap_years[$urandom_range(0, 7)]
                                            : $urandom_range(0, 9999);
        yw    = ($urandom_range(0, 99) < 85) ? 4 : $urandom_range(1, 5);
        if (kind < 90) begin
            append_digits(txt, day, $urandom_range(1, 2));
            txt = {txt, DOT_CHAR};
            append_digits(txt, month, $urandom_range(1, 2));
            txt = {txt, DOT_CHAR};
            append_digits(txt, year, yw);
            if (kind >= 75) begin
                at = $urandom_range(0, txt.size() - 1);
                case ($urandom_range(0, 2))
                    0: txt[at] = 8'($urandom_range(0, 255));
                    1: txt.delete(at);
                    default: txt.insert(at, noise_char());
                endcase
            end
        end else begin
            repeat ($urandom_range(1, 14)) txt = {txt, noise_char()};
        end
        send_text(txt);
    endtask

    initial begin
        t_in_word w;
        int target;
        int idle_plan[4];
        int stall_plan[4];

        // all inputs known from time zero
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_data      = '0;
        i_pop       = 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_token  = 0;
        hold_seen   = 0;
        hold_left   = 0;
        sent_chars  = 0;
        cycle_count = 0;
        sb = new();

        // phases: free-running, sender idle, receiver stall, both
        idle_plan  = '{0, 54, 0, 25};
        stall_plan = '{0, 0, 54, 25};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed texts: leap rule, year zero, zero day/month, length and
        // dot limits, bad characters, over-long fields
        send_string("29.02.2024");
        send_string("29.2.1900");
        send_string("29.02.2000");
        send_string("31.12.9999");
        send_string("1.1.0000");
        send_string("29.2.0000");
        send_string("00.01.2000");
        send_string("01.00.2000");
        send_string("31.04.2021");
        send_string("30.11.2021");
        send_string("01.01.20000");      // 11 chars, count saturates
        send_string("01.01.2000000");    // past saturation
        send_string("1.1.20.0");         // third dot
        send_string("1/1.2000");         // just below '0'
        send_string("1.1:2000");         // just above '9'
        send_string("130.1.2000");       // day field wraps, dot too late
        send_string("1.1.200");          // 7 chars
        w.ch = 8'hFF;
        w.last = 1'b1;
        send_word(w);
        w.ch = 8'h00;
        send_word(w);

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = idle_plan[ph];
            pop_stall_pct = stall_plan[ph];
            target = sent_chars + CHARS_PER_PHASE;
            while (sent_chars < target) send_random_text();

            // after the free-running phase: receiver holds off while short
            // texts pile up until the block raises full
            if (ph == 0) begin
                hold_token <= hold_token + 1;
                repeat (PRESSURE_TEXTS) begin
                    w.ch   = 8'($urandom_range(0, 255));
                    w.last = 1'b1;
                    send_word(w);
                end
            end
        end

        i_push <= 1'b0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
